FILE: hw/rtl/dap_pkg.sv
// ----------------------------------------------------------------------------
// DNS answer address parser package
// Shared types, codes and constants for the parser, its result buffer and top level.
// ----------------------------------------------------------------------------
package dap_pkg;

    localparam int unsigned HeaderBytes   = 12;
    localparam int unsigned QuestionFixed = 4;
    localparam int unsigned AnswerFixed   = 10;

    localparam logic [15:0] FLAG_QR      = 16'h8000;
    localparam logic [15:0] FLAG_RCODE   = 16'h000f;
    localparam logic [7:0]  PTR_MARK     = 8'hc0;
    localparam logic [15:0] TYPE_A       = 16'd1;
    localparam logic [15:0] INET_CLASS   = 16'd1;
    localparam logic [15:0] ADDR_RDLEN   = 16'd4;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_Q_NAME  = 4'd1,
        PH_Q_PTR   = 4'd2,
        PH_Q_FIXED = 4'd3,
        PH_A_NAME  = 4'd4,
        PH_A_PTR   = 4'd5,
        PH_A_FIXED = 4'd6,
        PH_A_SKIP  = 4'd7,
        PH_A_GRAB  = 4'd8,
        PH_DONE    = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_FOUND = 2'd1,
        VERDICT_ERROR = 2'd2
    } t_verdict;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  header_index;
        logic [15:0] questions_left;
        logic [15:0] answers_left;
        logic [7:0]  label_bytes_left;
        logic [3:0]  fixed_index;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [15:0] data_bytes_left;
        logic [31:0] captured_address;
        t_verdict    outcome;
        logic [3:0]  server_error;
    } t_parse_state;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] address;
        logic [3:0]  error_code;
    } t_result;

    localparam t_parse_state PARSE_CLEAR = '{
        phase:            PH_HEADER,
        header_index:     4'd0,
        questions_left:   16'd0,
        answers_left:     16'd0,
        label_bytes_left: 8'd0,
        fixed_index:      4'd0,
        record_type:      16'd0,
        record_class:     16'd0,
        data_bytes_left:  16'd0,
        captured_address: 32'd0,
        outcome:          VERDICT_NONE,
        server_error:     4'd0
    };

endpackage

FILE: hw/rtl/dap_if.sv
// ----------------------------------------------------------------------------
// DNS answer address parser channels
// Valid/ready channels for message bytes, results and the query id write.
// ----------------------------------------------------------------------------
interface dap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dap_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [31:0] address;
    logic [3:0]  error_code;

    modport source (output valid, output verdict, output address, output error_code,
                    input ready);
    modport sink   (input valid, input verdict, input address, input error_code,
                    output ready);
endinterface

interface dap_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] query_id;

    modport source (output valid, output query_id, input ready);
    modport sink   (input valid, input query_id, output ready);
endinterface

FILE: hw/rtl/dap_parser.sv
// ----------------------------------------------------------------------------
// DNS answer address parser core
// Walks header, questions and answers one byte per transfer and forms the
// verdict on the final byte of a message.
// ----------------------------------------------------------------------------
module dap_parser
    import dap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_query_id,
    input  logic        i_take,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_result_valid,
    output t_result     o_result
);

    logic [15:0]  r_query_id;
    t_parse_state r_state;
    t_parse_state n_state;
    t_parse_state s_step;

    always_comb begin
        s_step = r_state;
        unique case (r_state.phase)
            PH_HEADER: begin
                if (r_state.header_index < 4'd2) begin
                    s_step.record_type = {r_state.record_type[7:0], i_data_byte};
                end else if (r_state.header_index < 4'd4) begin
                    s_step.record_class = {r_state.record_class[7:0], i_data_byte};
                end else if (r_state.header_index < 4'd6) begin
                    s_step.questions_left = {r_state.questions_left[7:0], i_data_byte};
                end else if (r_state.header_index < 4'd8) begin
                    s_step.answers_left = {r_state.answers_left[7:0], i_data_byte};
                end
                s_step.header_index = r_state.header_index + 4'd1;
                if (s_step.header_index == 4'(HeaderBytes)) begin
                    priority if (s_step.record_type != r_query_id
                                 || (s_step.record_class & FLAG_QR) == 16'd0) begin
                        s_step.phase = PH_DONE;
                    end else if ((s_step.record_class & FLAG_RCODE) != 16'd0) begin
                        s_step.outcome      = VERDICT_ERROR;
                        s_step.server_error = s_step.record_class[3:0];
                        s_step.phase        = PH_DONE;
                    end else if (s_step.questions_left != 16'd0) begin
                        s_step.phase            = PH_Q_NAME;
                        s_step.label_bytes_left = 8'd0;
                    end else begin
                        s_step.phase = (s_step.answers_left != 16'd0) ? PH_A_NAME : PH_DONE;
                        s_step.label_bytes_left = 8'd0;
                    end
                end
            end
            PH_Q_NAME, PH_A_NAME: begin
                priority if (r_state.label_bytes_left != 8'd0) begin
                    s_step.label_bytes_left = r_state.label_bytes_left - 8'd1;
                end else if (i_data_byte == 8'd0) begin
                    s_step.phase       = (r_state.phase == PH_Q_NAME) ? PH_Q_FIXED : PH_A_FIXED;
                    s_step.fixed_index = 4'd0;
                end else if ((i_data_byte & PTR_MARK) == PTR_MARK) begin
                    s_step.phase = (r_state.phase == PH_Q_NAME) ? PH_Q_PTR : PH_A_PTR;
                end else begin
                    s_step.label_bytes_left = i_data_byte;
                end
            end
            PH_Q_PTR: begin
                s_step.phase       = PH_Q_FIXED;
                s_step.fixed_index = 4'd0;
            end
            PH_A_PTR: begin
                s_step.phase       = PH_A_FIXED;
                s_step.fixed_index = 4'd0;
            end
            PH_Q_FIXED: begin
                s_step.fixed_index = r_state.fixed_index + 4'd1;
                if (s_step.fixed_index == 4'(QuestionFixed)) begin
                    s_step.questions_left   = r_state.questions_left - 16'd1;
                    s_step.label_bytes_left = 8'd0;
                    if (s_step.questions_left != 16'd0) begin
                        s_step.phase = PH_Q_NAME;
                    end else begin
                        s_step.phase = (r_state.answers_left != 16'd0) ? PH_A_NAME : PH_DONE;
                    end
                end
            end
            PH_A_FIXED: begin
                if (r_state.fixed_index < 4'd2) begin
                    s_step.record_type = {r_state.record_type[7:0], i_data_byte};
                end else if (r_state.fixed_index < 4'd4) begin
                    s_step.record_class = {r_state.record_class[7:0], i_data_byte};
                end else if (r_state.fixed_index >= 4'd8) begin
                    s_step.data_bytes_left = {r_state.data_bytes_left[7:0], i_data_byte};
                end
                s_step.fixed_index = r_state.fixed_index + 4'd1;
                if (s_step.fixed_index == 4'(AnswerFixed)) begin
                    priority if (s_step.record_type == TYPE_A && s_step.record_class == INET_CLASS
                                 && s_step.data_bytes_left == ADDR_RDLEN) begin
                        s_step.captured_address = 32'd0;
                        s_step.phase            = PH_A_GRAB;
                    end else if (s_step.data_bytes_left != 16'd0) begin
                        s_step.phase = PH_A_SKIP;
                    end else begin
                        s_step.answers_left     = r_state.answers_left - 16'd1;
                        s_step.label_bytes_left = 8'd0;
                        s_step.phase = (s_step.answers_left != 16'd0) ? PH_A_NAME : PH_DONE;
                    end
                end
            end
            PH_A_SKIP: begin
                s_step.data_bytes_left = r_state.data_bytes_left - 16'd1;
                if (s_step.data_bytes_left == 16'd0) begin
                    s_step.answers_left     = r_state.answers_left - 16'd1;
                    s_step.label_bytes_left = 8'd0;
                    s_step.phase = (s_step.answers_left != 16'd0) ? PH_A_NAME : PH_DONE;
                end
            end
            PH_A_GRAB: begin
                s_step.captured_address = {r_state.captured_address[23:0], i_data_byte};
                s_step.data_bytes_left  = r_state.data_bytes_left - 16'd1;
                if (s_step.data_bytes_left == 16'd0) begin
                    s_step.outcome = VERDICT_FOUND;
                    s_step.phase   = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result_valid     = i_take && i_last_byte;
        o_result.verdict   = s_step.outcome;
        o_result.address   = (s_step.outcome == VERDICT_FOUND) ? s_step.captured_address : 32'd0;
        o_result.error_code = (s_step.outcome == VERDICT_ERROR) ? s_step.server_error : 4'd0;
        if (!i_take) begin
            n_state = r_state;
        end else if (i_last_byte) begin
            n_state = PARSE_CLEAR;
        end else begin
            n_state = s_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= PARSE_CLEAR;
            r_query_id <= 16'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_query_id <= i_cfg_query_id;
            end
        end
    end

endmodule

FILE: hw/rtl/dap_out_buf.sv
// ----------------------------------------------------------------------------
// DNS answer address parser result buffer
// Output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module dap_out_buf
    import dap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_head_valid;
    logic    r_skid_valid;
    t_result r_head;
    t_result r_skid;
    logic    s_head_free;

    assign s_head_free = !r_head_valid || i_ready;
    assign o_space     = !r_skid_valid;
    assign o_valid     = r_head_valid;
    assign o_data      = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (s_head_free) begin
            // advance skid into the output register, else load the new transfer
            if (r_skid_valid) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_head_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_head_free) begin
            r_head <= r_skid_valid ? r_skid : i_push_data;
        end else if (i_push) begin
            r_skid <= i_push_data;
        end
    end

endmodule

FILE: hw/rtl/dns_answer_address_parser_top.sv
// ----------------------------------------------------------------------------
// DNS answer address parser
// Parses a DNS response byte stream and reports the first A/IN address or the server error code.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                              | transfer
//  i_in     | in  | data_byte[7:0], last_byte            | valid && ready
//  o_out    | out | verdict[1:0], address[31:0], err[3:0]| valid && ready, last byte only
//  i_cfg    | in  | query_id[15:0]                       | valid && ready, always ready
//
//  One byte per cycle; the verdict appears in the output register the cycle
//  after the final byte is taken, or in the skid entry if the output register
//  is held. A one-entry skid stage keeps bytes flowing while a verdict waits;
//  input stalls only when both entries are full.
//  Synchronous active-low reset clears parse state, query id and the buffer.
// ----------------------------------------------------------------------------
module dns_answer_address_parser_top
    import dap_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    dap_byte_if.sink     i_in,
    dap_result_if.source o_out,
    dap_cfg_if.sink      i_cfg
);

    logic    s_take;
    logic    s_space;
    logic    s_push;
    t_result s_push_data;
    t_result s_out_data;

    assign i_in.ready  = s_space;
    assign s_take      = i_in.valid && s_space;
    assign i_cfg.ready = 1'b1;

    dap_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_query_id (i_cfg.query_id),
        .i_take         (s_take),
        .i_data_byte    (i_in.data_byte),
        .i_last_byte    (i_in.last_byte),
        .o_result_valid (s_push),
        .o_result       (s_push_data)
    );

    dap_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_push),
        .i_push_data (s_push_data),
        .o_space     (s_space),
        .o_valid     (o_out.valid),
        .o_data      (s_out_data),
        .i_ready     (o_out.ready)
    );

    assign o_out.verdict    = s_out_data.verdict;
    assign o_out.address    = s_out_data.address;
    assign o_out.error_code = s_out_data.error_code;

endmodule
